/* sv/srf_pkg.sv */
// srf_pkg: shared types, widths and register codes of the spread ratio filter.
// No dependencies; all other files but srf_ram refer to it by scoped names.
`timescale 1ns / 1ps

package srf_pkg;

    // Field widths
    localparam int SPREAD_BITS = 16;
    localparam int MAX_W       = 15;
    localparam int RATIO_W     = 16;
    localparam int LEN_W       = 7;
    localparam int Q_FRAC      = 8;

    // Window length is at most 127, so the window sum needs LEN_W more bits
    localparam int SUM_W = SPREAD_BITS + LEN_W;
    localparam int LHS_W = SPREAD_BITS + LEN_W + 1;
    localparam int RHS_W = RATIO_W + SUM_W + 1;

    // Ring and queue sizes
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPREAD = 2'd0,
        CFG_RATIO_Q8   = 2'd1,
        CFG_WINDOW_LEN = 2'd2
    } t_cfg_idx;

    localparam logic [MAX_W-1:0]   MAX_SPREAD_RST = 15'h7FFF;
    localparam logic [RATIO_W-1:0] RATIO_Q8_RST   = 16'h0000;
    localparam logic [LEN_W-1:0]   WINDOW_LEN_RST = 7'd20;

    // Item kinds
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SPREAD_BITS-1:0] spread;
    } t_in;

    typedef struct packed {
        logic pass_absolute;
        logic pass_relative;
        logic pass_both;
    } t_out;

    typedef struct packed {
        logic [MAX_W-1:0]   max_spread;
        logic [RATIO_W-1:0] ratio_q8;
        logic [LEN_W-1:0]   window_len;
    } t_cfg;

    // Classified check handed from the front end to the back end
    typedef struct packed {
        logic [SPREAD_BITS-1:0] spread;
        logic [LEN_W-1:0]       len;
        logic [SUM_W-1:0]       sum;
        logic                   abs_ok;
        logic                   bypass;
    } t_cmd;

endpackage

/* sv/spread_ratio_filter.sv */
// spread_ratio_filter: top level; configuration registers, front end, command
// queue and back end. Depends on srf_pkg, srf_front, srf_queue, srf_back.
`timescale 1ns / 1ps
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-----------------------------
//  item in   | in        | push / full            | i_item   (action, spread)
//  result    | out       | pop / empty            | o_result (absolute, relative,
//            |           |                        |           both)
//  config    | in        | i_cfg_we, i_cfg_idx    | i_cfg_wdata
//
//  One transaction is taken per clock while full is low. A record produces no
//  result; a check produces one result, which passes through the command
//  register loaded at acceptance, then a queue entry, the product register and
//  the result register before it reaches the result ports.
//  Reset is synchronous and leaves the history empty; no clearing pass runs,
//  the fill count masks the never-written ring entries.
//  full rises once the four-entry command queue plus the check in flight fill it;
//  a held result stalls only the back end until the queue backs up.

module spread_ratio_filter #(
    parameter int WINDOW_DEPTH = srf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            push,
    input  srf_pkg::t_in                    i_item,
    output logic                            full,
    // result channel
    output logic                            empty,
    input  logic                            pop,
    output srf_pkg::t_out                   o_result,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    srf_pkg::t_cfg               r_cfg;
    logic                        clear;
    logic                        q_push;
    srf_pkg::t_cmd               q_in;
    logic                        q_pop;
    srf_pkg::t_cmd               q_out;
    logic                        q_empty;
    logic [srf_pkg::QCNT_W-1:0]  q_count;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_spread <= srf_pkg::MAX_SPREAD_RST;
            r_cfg.ratio_q8   <= srf_pkg::RATIO_Q8_RST;
            r_cfg.window_len <= srf_pkg::WINDOW_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srf_pkg::CFG_MAX_SPREAD: begin
                    r_cfg.max_spread <= i_cfg_wdata[srf_pkg::MAX_W-1:0];
                end
                srf_pkg::CFG_RATIO_Q8: begin
                    r_cfg.ratio_q8 <= i_cfg_wdata[srf_pkg::RATIO_W-1:0];
                end
                srf_pkg::CFG_WINDOW_LEN: begin
                    r_cfg.window_len <= i_cfg_wdata[srf_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a new window length starts the history over
    assign clear = i_cfg_we && (i_cfg_idx == srf_pkg::CFG_WINDOW_LEN);

    srf_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_clear   (clear),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_q_count (q_count),
        .o_q_push  (q_push),
        .o_q_cmd   (q_in)
    );

    srf_queue #(
        .DEPTH (srf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    srf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ratio   (r_cfg.ratio_q8),
        .i_q_valid (!q_empty),
        .i_q_cmd   (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

/* sv/srf_ram.sv */
// srf_ram: generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No package dependency.
`timescale 1ns / 1ps

module srf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/srf_queue.sv */
// srf_queue: short FIFO of classified check commands between front and back end.
// Depends on srf_pkg (t_cmd).
`timescale 1ns / 1ps

module srf_queue #(
    parameter int DEPTH  = srf_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  srf_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output srf_pkg::t_cmd      o_cmd,
    output logic               o_empty,
    output logic [CNT_W-1:0]   o_count
);

    srf_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

    // the front end reserves room for every check it has in flight
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_cnt < CNT_W'(DEPTH))
        else $error("srf_queue: push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("srf_queue: pop from an empty queue");

endmodule

/* sv/srf_front.sv */
// srf_front: accepts transactions, keeps the bar ring, fill count and window sum,
// and classifies checks into commands for the back end. Depends on srf_pkg, srf_ram.
`timescale 1ns / 1ps

module srf_front #(
    parameter int WINDOW_DEPTH = srf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srf_pkg::t_cfg               i_cfg,
    input  logic                        i_clear,
    input  logic                        i_push,
    input  srf_pkg::t_in                i_item,
    output logic                        o_full,
    input  logic [srf_pkg::QCNT_W-1:0]  i_q_count,
    output logic                        o_q_push,
    output srf_pkg::t_cmd               o_q_cmd
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int IDX_W = ((PTR_W > srf_pkg::LEN_W) ? PTR_W : srf_pkg::LEN_W) + 1;
    localparam int FW    = srf_pkg::QCNT_W + 1;
    localparam int SB    = srf_pkg::SPREAD_BITS;
    localparam int SW    = srf_pkg::SUM_W;
    localparam int CW    = srf_pkg::SPREAD_BITS + srf_pkg::MAX_W;

    logic [srf_pkg::LEN_W-1:0] len;
    logic                      accept;
    logic                      rec_acc;
    logic                      chk_acc;
    logic                      win_full;
    logic [IDX_W-1:0]          old_sum;
    logic [PTR_W-1:0]          old_idx;
    logic                      abs_ok;
    logic [SB-1:0]             ring_rdata;
    logic [SW-1:0]             n_sum;

    // stage A state
    logic [PTR_W-1:0]          r_wp;
    logic [srf_pkg::LEN_W-1:0] r_count;
    // stage B
    logic                      r_b_rec;
    logic                      r_b_chk;
    logic                      r_b_sub;
    logic                      r_b_wfull;
    logic                      r_b_abs;
    logic [SB-1:0]             r_b_spread;
    logic [srf_pkg::LEN_W-1:0] r_b_len;
    logic [SW-1:0]             r_sum;

    // window length zero acts as one, beyond the ring acts as the ring depth
    always_comb begin
        if (i_cfg.window_len == '0) begin
            len = srf_pkg::LEN_W'(1);
        end else if (int'(i_cfg.window_len) > WINDOW_DEPTH) begin
            len = srf_pkg::LEN_W'(WINDOW_DEPTH);
        end else begin
            len = i_cfg.window_len;
        end
    end

    assign o_full  = (FW'(i_q_count) + FW'(r_b_chk)) >= FW'(srf_pkg::QUEUE_DEPTH);
    assign accept  = i_push && !o_full;
    assign rec_acc = accept && (i_item.action == srf_pkg::ACT_RECORD);
    assign chk_acc = accept && (i_item.action == srf_pkg::ACT_CHECK);
    assign win_full = (r_count >= len);

    // ring slot of the bar that leaves the window: write pointer minus length
    always_comb begin
        old_sum = IDX_W'(r_wp) + IDX_W'(WINDOW_DEPTH) - IDX_W'(len);
        if (old_sum >= IDX_W'(WINDOW_DEPTH)) begin
            old_sum = old_sum - IDX_W'(WINDOW_DEPTH);
        end
        old_idx = PTR_W'(old_sum);
    end

    assign abs_ok = !i_item.spread[SB-1] &&
                    (CW'(unsigned'(i_item.spread)) <= CW'(i_cfg.max_spread));

    srf_ram #(
        .WIDTH (SB),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (rec_acc),
        .i_waddr (r_wp),
        .i_wdata (i_item.spread),
        .i_re    (rec_acc),
        .i_raddr (old_idx),
        .o_rdata (ring_rdata)
    );

    always_comb begin
        n_sum = r_sum + {{(SW-SB){r_b_spread[SB-1]}}, r_b_spread};
        if (r_b_sub) begin
            n_sum = n_sum - {{(SW-SB){ring_rdata[SB-1]}}, ring_rdata};
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sub    <= win_full;
        r_b_wfull  <= win_full;
        r_b_abs    <= abs_ok;
        r_b_spread <= i_item.spread;
        r_b_len    <= len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_b_rec <= 1'b0;
            r_b_chk <= 1'b0;
        end else if (i_clear) begin
            r_wp    <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_b_rec <= 1'b0;
            r_b_chk <= 1'b0;
        end else begin
            r_b_rec <= rec_acc;
            r_b_chk <= chk_acc;
            if (rec_acc) begin
                r_wp <= (r_wp == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
                if (!win_full) begin
                    r_count <= r_count + srf_pkg::LEN_W'(1);
                end
            end
            if (r_b_rec) begin
                r_sum <= n_sum;
            end
        end
    end

    // a check sees the sum after every earlier record has been folded in
    assign o_q_push       = r_b_chk;
    assign o_q_cmd.spread = r_b_spread;
    assign o_q_cmd.len    = r_b_len;
    assign o_q_cmd.sum    = r_sum;
    assign o_q_cmd.abs_ok = r_b_abs;
    assign o_q_cmd.bypass = (i_cfg.ratio_q8 == '0) || !r_b_wfull ||
                            r_sum[SW-1] || (r_sum == '0);

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= len)
        else $error("srf_front: fill count beyond window length");

    a_chk_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_chk |-> $past(i_push && !o_full && i_item.action == srf_pkg::ACT_CHECK))
        else $error("srf_front: check in flight without an accepted transaction");

endmodule

/* sv/srf_back.sv */
// srf_back: evaluates queued checks: products, Q8.8 ratio compare, result register.
// Depends on srf_pkg (t_cmd, t_out, widths).
`timescale 1ns / 1ps

module srf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [srf_pkg::RATIO_W-1:0]  i_ratio,
    input  logic                         i_q_valid,
    input  srf_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output srf_pkg::t_out                o_result
);

    localparam int SB = srf_pkg::SPREAD_BITS;
    localparam int LW = srf_pkg::LHS_W;
    localparam int RW = srf_pkg::RHS_W;
    localparam int SW = srf_pkg::SUM_W;
    localparam int SH = srf_pkg::LHS_W + srf_pkg::Q_FRAC;

    logic                 out_ready;
    logic                 m_adv;
    logic signed [LW-1:0] lhs_a;
    logic signed [LW-1:0] lhs_b;
    logic signed [RW-1:0] rhs_a;
    logic signed [RW-1:0] rhs_b;
    logic signed [RW-1:0] lhs_cmp;
    logic [SH-1:0]        lhs_sh;
    logic                 rel_ok;

    logic                 r_m_v;
    logic signed [LW-1:0] r_m_lhs;
    logic signed [RW-1:0] r_m_rhs;
    logic                 r_m_abs;
    logic                 r_m_bypass;
    logic                 r_out_v;
    srf_pkg::t_out        r_out;

    assign out_ready = !r_out_v || i_pop;
    assign m_adv     = !r_m_v || out_ready;
    assign o_q_pop   = i_q_valid && m_adv;

    // spread * len and ratio * sum, both exact
    assign lhs_a = {{(LW-SB){i_q_cmd.spread[SB-1]}}, i_q_cmd.spread};
    assign lhs_b = LW'(i_q_cmd.len);
    assign rhs_a = {{(RW-SW){i_q_cmd.sum[SW-1]}}, i_q_cmd.sum};
    assign rhs_b = RW'(i_ratio);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_m_lhs    <= lhs_a * lhs_b;
            r_m_rhs    <= rhs_a * rhs_b;
            r_m_abs    <= i_q_cmd.abs_ok;
            r_m_bypass <= i_q_cmd.bypass;
        end
    end

    // spread*len*256 <= ratio*sum
    assign lhs_sh  = {r_m_lhs, srf_pkg::Q_FRAC'(0)};
    assign lhs_cmp = {{(RW-SH){lhs_sh[SH-1]}}, lhs_sh};
    assign rel_ok  = r_m_bypass || (lhs_cmp <= r_m_rhs);

    always_ff @(posedge i_clk) begin
        if (r_m_v && out_ready) begin
            r_out.pass_absolute <= r_m_abs;
            r_out.pass_relative <= rel_ok;
            r_out.pass_both     <= r_m_abs && rel_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (m_adv) begin
                r_m_v <= i_q_valid;
            end
            if (out_ready) begin
                r_out_v <= r_m_v;
            end
        end
    end

    assign o_empty  = !r_out_v;
    assign o_result = r_out;

endmodule

/* dv/spread_ratio_filter_test.sv */
// spread_ratio_filter_test: self-checking bench for the spread ratio filter.
// Depends on srf_pkg and spread_ratio_filter; a scoreboard class predicts each verdict.
`timescale 1ns / 1ps

// Tracks the bar history and register copies, predicts the verdict of every
// accepted check and compares it with what comes out of the block.
class verdict_scoreboard;
    logic signed [srf_pkg::SPREAD_BITS-1:0] bars [srf_pkg::WINDOW_DEPTH_DEF];
    int unsigned                            wr_ptr;
    int unsigned                            fill;
    longint                                 wsum;
    logic [srf_pkg::MAX_W-1:0]              max_lim;
    logic [srf_pkg::RATIO_W-1:0]            ratio;
    logic [srf_pkg::LEN_W-1:0]              len_reg;
    srf_pkg::t_out                          pending_verdicts [$];
    int                                     errors;

    function new();
        max_lim = srf_pkg::MAX_SPREAD_RST;
        ratio   = srf_pkg::RATIO_Q8_RST;
        len_reg = srf_pkg::WINDOW_LEN_RST;
        wr_ptr  = 0;
        fill    = 0;
        wsum    = 0;
        errors  = 0;
    endfunction

    // zero acts as one, anything past the ring depth is clipped to it
    function int unsigned eff_len();
        if (len_reg == 0) return 1;
        if (len_reg > srf_pkg::WINDOW_DEPTH_DEF) return srf_pkg::WINDOW_DEPTH_DEF;
        return len_reg;
    endfunction

    function void write_reg(srf_pkg::t_cfg_idx idx, logic [srf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            srf_pkg::CFG_MAX_SPREAD: max_lim = data[srf_pkg::MAX_W-1:0];
            srf_pkg::CFG_RATIO_Q8:   ratio   = data[srf_pkg::RATIO_W-1:0];
            srf_pkg::CFG_WINDOW_LEN: begin
                len_reg = data[srf_pkg::LEN_W-1:0];
                wr_ptr  = 0;
                fill    = 0;
                wsum    = 0;
            end
            default: ;
        endcase
    endfunction

    // largest spread that still passes the relative test (stimulus aiming only)
    function longint rel_limit();
        if (wsum <= 0) return 0;
        return (longint'(ratio) * wsum) / (longint'(eff_len()) * 256);
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void note_item(srf_pkg::t_in it);
        int unsigned   L;
        int unsigned   old;
        longint        s;
        srf_pkg::t_out v;
        L = eff_len();
        s = longint'(it.spread);
        if (it.action == srf_pkg::ACT_RECORD) begin
            if (fill >= L) begin
                old = (wr_ptr + srf_pkg::WINDOW_DEPTH_DEF - L) % srf_pkg::WINDOW_DEPTH_DEF;
                wsum -= longint'(bars[old]);
            end else begin
                fill++;
            end
            bars[wr_ptr] = it.spread;
            wsum += s;
            wr_ptr = (wr_ptr + 1) % srf_pkg::WINDOW_DEPTH_DEF;
        end else begin
            v.pass_absolute = (s >= 0) && (s <= longint'(max_lim));
            if (ratio == 0 || fill < L || wsum <= 0) v.pass_relative = 1'b1;
            else v.pass_relative = (s * longint'(L) * 256) <= (longint'(ratio) * wsum);
            v.pass_both = v.pass_absolute & v.pass_relative;
            pending_verdicts.push_back(v);
        end
    endfunction

    function void check_verdict(srf_pkg::t_out got);
        srf_pkg::t_out exp;
        if (pending_verdicts.size() == 0) begin
            report($sformatf("result %b with no check outstanding", got));
            return;
        end
        exp = pending_verdicts.pop_front();
        if (got.pass_absolute !== exp.pass_absolute ||
            got.pass_relative !== exp.pass_relative ||
            got.pass_both !== exp.pass_both)
            report($sformatf("abs/rel/both expected %b%b%b got %b%b%b",
                exp.pass_absolute, exp.pass_relative, exp.pass_both,
                got.pass_absolute, got.pass_relative, got.pass_both));
    endfunction
endclass

module spread_ratio_filter_test;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    srf_pkg::t_in                    i_item = '0;
    logic                            full;
    logic                            empty;
    logic                            pop = 1'b0;
    srf_pkg::t_out                   o_result;
    logic                            i_cfg_we = 1'b0;
    logic [srf_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [srf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    verdict_scoreboard sb = new();

    // Gaps on both sides are switched off for the steady phase
    bit no_gaps = 1'b0;
    // Magnitude of random bar spreads in the current phase
    int unsigned bar_span = 100;

    // Phase table: register settings, bar magnitude, gap policy, item count.
    // Covers len 1 and 64, the out-of-range lengths 0 and 127, ratio 0 / 1 /
    // 65535, and max_spread at both ends.
    localparam int N_PHASES = 8;
    int unsigned ph_max   [N_PHASES] = '{32767, 0,     1000, 500, 32767, 0,   20000, 32767};
    int unsigned ph_ratio [N_PHASES] = '{256,   65535, 384,  200, 1,     0,   0,     512};
    int unsigned ph_len   [N_PHASES] = '{1,     64,    4,    0,   127,   0,   8,     2};
    int unsigned ph_span  [N_PHASES] = '{100,   2000,  1000, 300, 32767, 500, 1000,  50};
    bit          ph_quiet [N_PHASES] = '{0,     0,     1,    0,   0,     0,   0,     0};
    int unsigned ph_items [N_PHASES] = '{60,    80,    100,  60,  80,    80,  60,    80};

    spread_ratio_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: pop is rerolled every falling edge; held high in the steady phase
    always @(negedge i_clk) begin
        pop <= i_rst_n && (no_gaps || $urandom_range(99) >= 25);
    end

    // Monitor: both handshakes are observed at the rising edge, with the values
    // that were settled since the previous falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_item(i_item);
            if (pop && !empty) sb.check_verdict(o_result);
        end
    end

    function automatic srf_pkg::t_in make_item(logic act, longint value);
        srf_pkg::t_in it;
        it.action = act;
        it.spread = srf_pkg::SPREAD_BITS'(value);
        return it;
    endfunction

    // Clamp into the signed spread range so aimed values do not wrap around
    function automatic longint clamp_spread(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Mix for the random part: records are mostly well-behaved positive bars so
    // the window fills and the sum stays positive; checks are aimed at the
    // relative threshold and at max_spread, with some fully random noise.
    function automatic srf_pkg::t_in random_item();
        int unsigned pick;
        longint      v;
        logic        act;
        pick = $urandom_range(99);
        act  = ($urandom_range(99) < 55) ? srf_pkg::ACT_RECORD : srf_pkg::ACT_CHECK;
        if (act == srf_pkg::ACT_RECORD) begin
            if (pick < 70)      v = $urandom_range(bar_span);
            else if (pick < 85) v = -longint'($urandom_range(bar_span / 4 + 1));
            else                v = longint'($signed(srf_pkg::SPREAD_BITS'($urandom)));
        end else begin
            if (pick < 40)      v = sb.rel_limit() + $urandom_range(4) - 2;
            else if (pick < 60) v = longint'(sb.max_lim) + $urandom_range(4) - 2;
            else if (pick < 80) v = $urandom_range(2 * bar_span);
            else                v = longint'($signed(srf_pkg::SPREAD_BITS'($urandom)));
        end
        return make_item(act, clamp_spread(v));
    endfunction

    // One input transaction. Entered and left at a falling edge; push stays
    // high between back-to-back items.
    task automatic send_item(input srf_pkg::t_in it);
        while (!no_gaps && $urandom_range(99) < 25) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and let the block settle: every check answered, then a wait
    // for records still in the pipeline.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input srf_pkg::t_cfg_idx idx,
                             input logic [srf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Writes all three registers; spare upper data bits are randomized since
    // the block must ignore them.
    task automatic set_config(input int unsigned mx, input int unsigned rq,
                              input int unsigned ln);
        write_reg(srf_pkg::CFG_MAX_SPREAD, {1'($urandom), srf_pkg::MAX_W'(mx)});
        write_reg(srf_pkg::CFG_RATIO_Q8, srf_pkg::RATIO_W'(rq));
        write_reg(srf_pkg::CFG_WINDOW_LEN, {9'($urandom), srf_pkg::LEN_W'(ln)});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned mx, rq, ln;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: relative test disabled, so only the absolute test
        // decides; spread extremes and the sign boundary.
        send_item(make_item(srf_pkg::ACT_CHECK, -32768));
        send_item(make_item(srf_pkg::ACT_CHECK, 32767));
        send_item(make_item(srf_pkg::ACT_CHECK, 0));
        send_item(make_item(srf_pkg::ACT_CHECK, -1));
        drain();

        // Three-bar window at ratio 1.0, max_spread 100
        set_config(100, 256, 3);
        send_item(make_item(srf_pkg::ACT_CHECK, 100));     // window not full: bypass
        send_item(make_item(srf_pkg::ACT_CHECK, 101));     // just over max_spread
        send_item(make_item(srf_pkg::ACT_RECORD, 10));
        send_item(make_item(srf_pkg::ACT_RECORD, 20));
        send_item(make_item(srf_pkg::ACT_RECORD, 30));
        send_item(make_item(srf_pkg::ACT_CHECK, 20));      // exactly at the average
        send_item(make_item(srf_pkg::ACT_CHECK, 21));      // one over the average
        send_item(make_item(srf_pkg::ACT_CHECK, -5));      // negative candidate
        send_item(make_item(srf_pkg::ACT_RECORD, -100));
        send_item(make_item(srf_pkg::ACT_RECORD, -100));
        send_item(make_item(srf_pkg::ACT_CHECK, 50));      // negative window sum: bypass
        send_item(make_item(srf_pkg::ACT_RECORD, 0));
        send_item(make_item(srf_pkg::ACT_RECORD, 0));
        send_item(make_item(srf_pkg::ACT_RECORD, 0));
        send_item(make_item(srf_pkg::ACT_CHECK, 5));       // zero window sum: bypass
        send_item(make_item(srf_pkg::ACT_RECORD, 32767));
        send_item(make_item(srf_pkg::ACT_RECORD, -32768));
        send_item(make_item(srf_pkg::ACT_CHECK, 0));
        drain();

        // Random phases; phase 5 draws its settings at random
        for (int p = 0; p < N_PHASES; p++) begin
            mx = (p == 5) ? $urandom_range(32767) : ph_max[p];
            rq = (p == 5) ? $urandom_range(1, 1024) : ph_ratio[p];
            ln = (p == 5) ? $urandom_range(1, 64) : ph_len[p];
            set_config(mx, rq, ln);
            bar_span = ph_span[p];
            no_gaps  = ph_quiet[p];
            for (int n = 0; n < ph_items[p]; n++) send_item(random_item());
            drain();
            no_gaps = 1'b0;
        end

        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
            $display("spread_ratio_filter_test: PASS");
        end else begin
            $display("spread_ratio_filter_test: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #400us;
        $display("spread_ratio_filter_test: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/srf_pkg.sv
sv/srf_ram.sv
sv/srf_queue.sv
sv/srf_front.sv
sv/srf_back.sv
sv/spread_ratio_filter.sv
dv/spread_ratio_filter_test.sv
